// File: sv/crsm_pkg.sv
// crsm_pkg: shared types and constants for the codepoint range set matcher
// no dependencies
package crsm_pkg;
    localparam int MaxRanges = 16;
    localparam int IdxW = $clog2(MaxRanges);
    localparam int CntW = $clog2(MaxRanges + 1);
    localparam int CpW = 21;

    localparam logic [0:0] ReqAdd = 1'b0;
    localparam logic [0:0] ReqTest = 1'b1;
    localparam logic [0:0] RegInvert = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INS,
        ST_MERGE,
        ST_COMPACT,
        ST_OUT
    } state_t;
endpackage

// File: sv/codepoint_range_set_matcher.sv
// codepoint_range_set_matcher: sorted disjoint range table with add and test requests
// depends on crsm_pkg
//
// channel | dir | transaction
// s_axis  | in  | tuser = req_type, tdata = bound_a, bound_b, code
// m_axis  | out | tdata = is_member, overflow, range_count
// apb     | in  | register 0 = invert_match
//
// each request scans the table one entry per cycle through a memory with one
// read port and one write port and a registered read; every entry that an add
// moves is first read and then written
// insert shifts entries up walking downward, merge compacts walking upward
// reset (aresetn low, synchronous) empties the table; entries are not cleared
// the input is stalled while a request is in work; a finished result waits in
// the output register, and the next finished request holds until it is taken
module codepoint_range_set_matcher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // bound_a[20:0], bound_b[41:21], code[62:42]
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // is_member[0], overflow[1], range_count[6:2]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int IW = crsm_pkg::IdxW;
    localparam int CW = crsm_pkg::CntW;
    localparam int PW = crsm_pkg::CpW;

    // table memory: one entry holds {low, high}
    logic [2*PW-1:0] mem [crsm_pkg::MaxRanges];
    logic [2*PW-1:0] rd_data;
    logic [IW-1:0]   rd_addr, wr_addr;
    logic            wr_en;
    logic [2*PW-1:0] wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

    wire [PW-1:0] e_lo = rd_data[2*PW-1:PW];
    wire [PW-1:0] e_hi = rd_data[PW-1:0];

    crsm_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] k_reg, k_next;        // read pointer in scan and compaction, destination in insert
    logic          rd_pend_reg, rd_pend_next;  // in scan, rd_data holds entry k_reg-1
    logic [CW-1:0] i_reg, i_next;        // first touched entry
    logic [CW-1:0] j_reg, j_next;        // first entry beyond range
    logic          found_i_reg, found_i_next;
    logic          req_reg;
    logic [PW-1:0] lo_reg, lo_next, hi_reg, hi_next, code_reg;
    logic          hit_reg, hit_next;
    logic          ovf_reg, ovf_next;
    logic          inv_reg;
    logic          outv_reg;
    logic [6:0]    m_data_reg;
    logic [PW:0]   lo_w, hi_w1;

    assign lo_w  = {1'b0, lo_reg};
    assign hi_w1 = {1'b0, hi_reg} + 1'b1;

    // configuration
    wire cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = {31'd0, inv_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) inv_reg <= 1'b0;
        else if (cfg_wr && paddr == 2'(4 * crsm_pkg::RegInvert)) inv_reg <= pwdata[0];
    end

    assign s_axis_tready = (state_reg == crsm_pkg::ST_IDLE);
    assign m_axis_tvalid = outv_reg;
    assign m_axis_tdata  = {1'b0, m_data_reg};
    wire s_acc = s_axis_tvalid && s_axis_tready;
    // finished request moves into the output register once it is free
    wire out_load = (state_reg == crsm_pkg::ST_OUT) && (!outv_reg || m_axis_tready);

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            req_reg  <= s_axis_tuser;
            code_reg <= s_axis_tdata[62:42];
        end
    end

    // next state and datapath
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        rd_pend_next = 1'b0;
        i_next       = i_reg;
        j_next       = j_reg;
        found_i_next = found_i_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        hit_next     = hit_reg;
        ovf_next     = ovf_reg;
        rd_addr      = k_reg[IW-1:0];
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        unique case (state_reg)
            crsm_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (s_axis_tdata[20:0] <= s_axis_tdata[41:21]) begin
                        lo_next = s_axis_tdata[20:0];
                        hi_next = s_axis_tdata[41:21];
                    end else begin
                        lo_next = s_axis_tdata[41:21];
                        hi_next = s_axis_tdata[20:0];
                    end
                    k_next       = '0;
                    found_i_next = 1'b0;
                    i_next       = count_reg;
                    j_next       = count_reg;
                    hit_next     = 1'b0;
                    ovf_next     = 1'b0;
                    state_next   = crsm_pkg::ST_SCAN;
                end
            end
            crsm_pkg::ST_SCAN: begin
                // examine entry k_reg-1 when pending, issue read of k_reg
                if (rd_pend_reg) begin
                    if (req_reg == crsm_pkg::ReqTest) begin
                        if (e_lo <= code_reg && code_reg <= e_hi) hit_next = 1'b1;
                    end else begin
                        if (!found_i_reg && ({1'b0, e_hi} + 1'b1) >= lo_w) begin
                            found_i_next = 1'b1;
                            i_next       = k_reg - 1'b1;
                        end
                        if ((found_i_reg || ({1'b0, e_hi} + 1'b1) >= lo_w)
                            && {1'b0, e_lo} > hi_w1 && j_reg == count_reg)
                            j_next = k_reg - 1'b1;
                        // merge extents of touched entries
                        if ((found_i_reg || ({1'b0, e_hi} + 1'b1) >= lo_w)
                            && {1'b0, e_lo} <= hi_w1 && j_reg == count_reg) begin
                            if (e_lo < lo_reg) lo_next = e_lo;
                            if (e_hi > hi_reg) hi_next = e_hi;
                        end
                    end
                end
                if (k_reg < count_reg) begin
                    k_next       = k_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end else if (!rd_pend_reg) begin
                    if (req_reg == crsm_pkg::ReqTest) begin
                        hit_next   = hit_reg ^ inv_reg;
                        state_next = crsm_pkg::ST_OUT;
                    end else if (i_reg == j_reg) begin
                        if (count_reg >= CW'(crsm_pkg::MaxRanges)) begin
                            ovf_next   = 1'b1;
                            state_next = crsm_pkg::ST_OUT;
                        end else begin
                            k_next     = count_reg;
                            state_next = crsm_pkg::ST_INS;
                        end
                    end else begin
                        k_next     = j_reg;
                        state_next = crsm_pkg::ST_MERGE;
                    end
                end
            end
            crsm_pkg::ST_INS: begin
                // k_reg is destination; read k-1 then write it to k
                if (k_reg > i_reg) begin
                    rd_addr = IW'(k_reg - 1'b1);
                    if (rd_pend_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = k_reg[IW-1:0];
                        wr_data = rd_data;
                        k_next  = k_reg - 1'b1;
                    end else begin
                        rd_pend_next = 1'b1;
                    end
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = i_reg[IW-1:0];
                    wr_data    = {lo_reg, hi_reg};
                    count_next = count_reg + 1'b1;
                    state_next = crsm_pkg::ST_OUT;
                end
            end
            crsm_pkg::ST_MERGE: begin
                wr_en   = 1'b1;
                wr_addr = i_reg[IW-1:0];
                wr_data = {lo_reg, hi_reg};
                // absorbed = j - i - 1; move j.. down to i+1..
                k_next     = j_reg;
                state_next = crsm_pkg::ST_COMPACT;
            end
            crsm_pkg::ST_COMPACT: begin
                if (k_reg < count_reg) begin
                    rd_addr = k_reg[IW-1:0];
                    if (rd_pend_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = IW'(k_reg - j_reg + i_reg + 1'b1);
                        wr_data = rd_data;
                        k_next  = k_reg + 1'b1;
                    end else begin
                        rd_pend_next = 1'b1;
                    end
                end else begin
                    count_next = count_reg - (j_reg - i_reg - 1'b1);
                    state_next = crsm_pkg::ST_OUT;
                end
            end
            crsm_pkg::ST_OUT: begin
                if (!outv_reg || m_axis_tready) state_next = crsm_pkg::ST_IDLE;
            end
            default: state_next = crsm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= crsm_pkg::ST_IDLE;
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
            outv_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_pend_reg <= rd_pend_next;
            if (out_load) outv_reg <= 1'b1;
            else if (m_axis_tready) outv_reg <= 1'b0;
        end
    end

    // output register: range_count, overflow, is_member
    always_ff @(posedge aclk) begin
        if (out_load) m_data_reg <= {count_reg, ovf_reg, hit_reg};
    end

    always_ff @(posedge aclk) begin
        k_reg       <= k_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        found_i_reg <= found_i_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        hit_reg     <= hit_next;
        ovf_reg     <= ovf_next;
    end

    // count never exceeds the table size
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(crsm_pkg::MaxRanges))
        else $error("range count beyond table size");

    // an overflow result always reports a full table
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_data_reg[1]) |-> m_data_reg[6:2] == CW'(crsm_pkg::MaxRanges))
        else $error("overflow with room left");

    // a test request never changes the count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == crsm_pkg::ST_SCAN && req_reg == crsm_pkg::ReqTest)
        |=> count_reg == $past(count_reg))
        else $error("test changed the count");
endmodule

// File: dv/tb.sv
// tb: self-checking testbench for codepoint_range_set_matcher
// depends on crsm_pkg and the codepoint_range_set_matcher rtl
// predicts every result from a shadow range table and compares field by field
module tb;
    localparam int CycleLimit = 400000;

    typedef struct packed {
        logic [0:0]               req;
        logic [crsm_pkg::CpW-1:0] bound_a;
        logic [crsm_pkg::CpW-1:0] bound_b;
        logic [crsm_pkg::CpW-1:0] code;
    } request_t;

    // lowest bit last, matching the result tdata layout
    typedef struct packed {
        logic [4:0] range_count;
        logic       overflow;
        logic       is_member;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    codepoint_range_set_matcher dut (.*);

    // 8 unit period
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // shadow of the block's range table and register
    int unsigned shadow_lo [crsm_pkg::MaxRanges];
    int unsigned shadow_hi [crsm_pkg::MaxRanges];
    int unsigned shadow_count = 0;
    bit          shadow_invert = 1'b0;

    request_t pending_reqs [$];
    answer_t  expected_answers [$];
    request_t cur_req;
    int       errs = 0;
    int       n_accepted = 0;
    bit       idle_on = 1'b1;
    int       cycles = 0;

    // merge lo..hi into the shadow table, returns 1 when rejected as full
    function automatic bit shadow_add(int unsigned lo, int unsigned hi);
        int unsigned i = 0;
        int unsigned j;
        int unsigned absorbed;
        while (i < shadow_count && shadow_hi[i] + 1 < lo) i++;
        j = i;
        while (j < shadow_count && shadow_lo[j] <= hi + 1) j++;
        if (j == i) begin
            if (shadow_count >= crsm_pkg::MaxRanges) return 1'b1;
            for (int unsigned k = shadow_count; k > i; k--) begin
                shadow_lo[k] = shadow_lo[k-1];
                shadow_hi[k] = shadow_hi[k-1];
            end
            shadow_lo[i] = lo;
            shadow_hi[i] = hi;
            shadow_count++;
            return 1'b0;
        end
        if (shadow_lo[i] < lo) lo = shadow_lo[i];
        if (shadow_hi[j-1] > hi) hi = shadow_hi[j-1];
        shadow_lo[i] = lo;
        shadow_hi[i] = hi;
        absorbed = j - i - 1;
        if (absorbed != 0) begin
            for (int unsigned k = j; k < shadow_count; k++) begin
                shadow_lo[k-absorbed] = shadow_lo[k];
                shadow_hi[k-absorbed] = shadow_hi[k];
            end
            shadow_count -= absorbed;
        end
        return 1'b0;
    endfunction

    function automatic answer_t predict_answer(request_t r);
        answer_t ans;
        bit hit = 1'b0;
        ans = '0;
        if (r.req == crsm_pkg::ReqAdd) begin
            if (r.bound_a <= r.bound_b) ans.overflow = shadow_add(r.bound_a, r.bound_b);
            else ans.overflow = shadow_add(r.bound_b, r.bound_a);
        end else begin
            for (int unsigned k = 0; k < shadow_count; k++)
                if (shadow_lo[k] <= r.code && r.code <= shadow_hi[k]) hit = 1'b1;
            ans.is_member = hit ^ shadow_invert;
        end
        ans.range_count = shadow_count[4:0];
        return ans;
    endfunction

    // driver: offers queued requests with random idle bursts
    int send_gap = 0;
    always @(posedge aclk) begin
        logic nv;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_answers.push_back(predict_answer(cur_req));
                n_accepted <= n_accepted + 1;
            end
            nv = 1'b0;
            if (s_axis_tvalid && !s_axis_tready) begin
                nv = 1'b1;  // hold the offered transaction
            end else if (send_gap > 0) begin
                send_gap--;
            end else if (pending_reqs.size() > 0) begin
                if (idle_on && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 6);
                end else begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tdata <= {1'b0, cur_req.code, cur_req.bound_b, cur_req.bound_a};
                    s_axis_tuser <= cur_req.req;
                    nv = 1'b1;
                end
            end
            s_axis_tvalid <= nv;
        end
    end

    // monitor: checks results, random backpressure plus one long hold-off
    int  recv_gap = 0;
    int  stall_left = 0;
    bit  stall_done = 1'b0;
    always @(posedge aclk) begin
        answer_t got;
        answer_t want;
        logic rdy;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[6:0];
                if (expected_answers.size() == 0) begin
                    $error("result with nothing expected: %h", m_axis_tdata);
                    errs++;
                end else begin
                    want = expected_answers.pop_front();
                    if (got.is_member !== want.is_member) begin
                        $error("is_member expected %0d got %0d", want.is_member, got.is_member);
                        errs++;
                    end
                    if (got.overflow !== want.overflow) begin
                        $error("overflow expected %0d got %0d", want.overflow, got.overflow);
                        errs++;
                    end
                    if (got.range_count !== want.range_count) begin
                        $error("range_count expected %0d got %0d",
                               want.range_count, got.range_count);
                        errs++;
                    end
                end
            end
            // long hold-off once, sender keeps offering so the input stalls
            if (n_accepted == 60 && !stall_done) begin
                stall_done = 1'b1;
                stall_left = 300;
            end
            rdy = 1'b1;
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                rdy = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                recv_gap = $urandom_range(0, 6);
                rdy = 1'b0;
            end
            m_axis_tready <= rdy;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_req(logic [0:0] req, int unsigned a, int unsigned b, int unsigned c);
        request_t r;
        r.req = req;
        r.bound_a = a[crsm_pkg::CpW-1:0];
        r.bound_b = b[crsm_pkg::CpW-1:0];
        r.code = c[crsm_pkg::CpW-1:0];
        pending_reqs.push_back(r);
    endtask

    // waits until the block is drained and every expected result has arrived, then idles
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_answers.size() != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_invert(bit val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 2'(4 * crsm_pkg::RegInvert);
        pwdata <= {$urandom_range(0, 1) ? 31'h7fffffff : 31'h0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_invert = val;
    endtask

    // mostly clustered adds and tests so merges, bridges and overflow all occur
    task automatic queue_random(int n);
        int unsigned base;
        int unsigned a;
        int unsigned w;
        int r;
        base = $urandom_range(0, 21'h1FFFFF - 5000);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            a = base + $urandom_range(0, 4000);
            if (r < 30) begin
                queue_req(crsm_pkg::ReqTest, $urandom, $urandom, a);
            end else if (r < 45) begin
                queue_req(crsm_pkg::ReqTest, $urandom, $urandom, $urandom_range(0, 21'h1FFFFF));
            end else if (r < 85) begin
                w = $urandom_range(0, 40);
                if ($urandom_range(0, 1)) queue_req(crsm_pkg::ReqAdd, a, a + w, $urandom);
                else queue_req(crsm_pkg::ReqAdd, a + w, a, $urandom);
            end else if (r < 92) begin
                queue_req(crsm_pkg::ReqAdd, a, a + $urandom_range(0, 3000), $urandom);
            end else begin
                queue_req(crsm_pkg::ReqAdd, $urandom_range(0, 21'h1FFFFF),
                          $urandom_range(0, 21'h1FFFFF), $urandom);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        write_invert(1'b0);

        // directed: extremes, reversed bounds, adjacency, covered, full table
        queue_req(crsm_pkg::ReqTest, 0, 0, 0);
        queue_req(crsm_pkg::ReqAdd, 21'h1FFFFF, 21'h1FFFFF, 0);
        queue_req(crsm_pkg::ReqTest, 0, 0, 21'h1FFFFF);
        queue_req(crsm_pkg::ReqAdd, 0, 0, 21'h1FFFFF);
        queue_req(crsm_pkg::ReqTest, 0, 0, 0);
        queue_req(crsm_pkg::ReqAdd, 10, 5, 0);
        queue_req(crsm_pkg::ReqAdd, 11, 11, 0);
        queue_req(crsm_pkg::ReqAdd, 3, 4, 0);
        queue_req(crsm_pkg::ReqAdd, 6, 7, 0);
        queue_req(crsm_pkg::ReqTest, 0, 0, 12);
        queue_req(crsm_pkg::ReqTest, 0, 0, 2);
        for (int k = 1; k <= 14; k++) queue_req(crsm_pkg::ReqAdd, 100 * k, 100 * k + 1, 0);
        queue_req(crsm_pkg::ReqAdd, 21'h10FFFF, 21'h10FFFF, 0);
        queue_req(crsm_pkg::ReqAdd, 99, 1500, 0);
        queue_req(crsm_pkg::ReqTest, 0, 0, 700);
        wait_drained();

        write_invert(1'b1);
        queue_req(crsm_pkg::ReqTest, 0, 0, 700);
        queue_req(crsm_pkg::ReqTest, 0, 0, 5000);
        queue_random(150);
        wait_drained();

        write_invert(1'b0);
        queue_random(150);
        wait_drained();

        // last part without idling
        idle_on = 1'b0;
        write_invert(1'b1);
        queue_random(150);
        wait_drained();

        if (errs == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
